/* rtl/cau_pkg.sv */
// ----------------------------------------------------------------------------
// cau_pkg
// shared types, codes and saturation helper of the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam int unsigned DW = 32;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_CONJ = 3'd4,
		OP_NEG  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_DIV0 = 2'd2
	} status_t;

	localparam logic signed [64:0] MAX65 = 65'sd2147483647;
	localparam logic signed [64:0] MIN65 = -65'sd2147483648;

	typedef struct packed {
		logic [DW-1:0] v;
		logic          f;
	} sat_t;

	typedef struct packed {
		logic          valid;
		logic          is_div;
		logic          neg_re;
		logic          neg_im;
		logic          ovf_re;
		logic          ovf_im;
		logic [DW-1:0] res_re;
		logic [DW-1:0] res_im;
		status_t       status;
	} ctl_t;

	function automatic sat_t sat65(logic signed [64:0] x);
		sat_t s;
		begin
			if (x > MAX65) begin
				s.v = 32'h7fff_ffff;
				s.f = 1'b1;
			end else if (x < MIN65) begin
				s.v = 32'h8000_0000;
				s.f = 1'b1;
			end else begin
				s.v = x[31:0];
				s.f = 1'b0;
			end
			return s;
		end
	endfunction

endpackage

/* rtl/complex_arith_unit.sv */
// ----------------------------------------------------------------------------
// complex_arith_unit
// pipelined fixed-point complex ALU: add, sub, mul, div, conjugate, negate
// ----------------------------------------------------------------------------
// request channel: req_valid/req_stall carry kind and the operands a and b,
// result channel: res_valid/res_stall carry res_re, res_im and status
// a request is taken when valid is high and stall low; one result per request
// the pipeline holds three front stages, a divider chain of 32 + FRAC_BITS
// cells with one quotient bit per cell, and the output register; every
// operation runs the same path, so results leave in request order
// throughput is one request per cycle while res_stall is low
// when a result is waiting and res_stall is high the whole pipeline holds
// and req_stall rises in the same cycle; nothing is dropped
// reset clears all valid flags; no result is shown until a request arrives
// ----------------------------------------------------------------------------
module complex_arith_unit #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [2:0]         kind,
	input  logic signed [31:0] a_re,
	input  logic signed [31:0] a_im,
	input  logic signed [31:0] b_re,
	input  logic signed [31:0] b_im,
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [31:0] res_re,
	output logic signed [31:0] res_im,
	output logic [1:0]         status
);

	localparam int unsigned W = 32 + FRAC_BITS;

	logic en;
	logic res_valid_q;

	assign en        = !(res_valid_q && res_stall);
	assign req_stall = !en;

	cau_pkg::ctl_t ctl_c   [0:W];
	logic [63:0]   den_c   [0:W];
	logic [63:0]   r_re_c  [0:W];
	logic [63:0]   r_im_c  [0:W];
	logic [W-1:0]  dv_re_c [0:W];
	logic [W-1:0]  dv_im_c [0:W];
	logic [W-1:0]  q_re_c  [0:W];
	logic [W-1:0]  q_im_c  [0:W];

	cau_front #(
		.FRAC_BITS(FRAC_BITS),
		.W(W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.vld(req_valid),
		.kind(kind),
		.a_re(a_re),
		.a_im(a_im),
		.b_re(b_re),
		.b_im(b_im),
		.ctl(ctl_c[0]),
		.r_re(r_re_c[0]),
		.r_im(r_im_c[0]),
		.dv_re(dv_re_c[0]),
		.dv_im(dv_im_c[0]),
		.den(den_c[0])
	);

	assign q_re_c[0] = '0;
	assign q_im_c[0] = '0;

	for (genvar i = 0; i < W; i++) begin : g_cell
		cau_div_cell #(
			.W(W)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.ctl_i(ctl_c[i]),
			.den_i(den_c[i]),
			.r_re_i(r_re_c[i]),
			.r_im_i(r_im_c[i]),
			.dv_re_i(dv_re_c[i]),
			.dv_im_i(dv_im_c[i]),
			.q_re_i(q_re_c[i]),
			.q_im_i(q_im_c[i]),
			.ctl_o(ctl_c[i+1]),
			.den_o(den_c[i+1]),
			.r_re_o(r_re_c[i+1]),
			.r_im_o(r_im_c[i+1]),
			.dv_re_o(dv_re_c[i+1]),
			.dv_im_o(dv_im_c[i+1]),
			.q_re_o(q_re_c[i+1]),
			.q_im_o(q_im_c[i+1])
		);
	end

	// quotient sign, saturation and final selection
	cau_pkg::ctl_t fc;
	logic [W-1:0]  fq_re, fq_im;
	logic [31:0]   f_re, f_im;
	logic          sat_re, sat_im;
	logic [1:0]    f_st;

	always_comb begin
		fc     = ctl_c[W];
		fq_re  = q_re_c[W];
		fq_im  = q_im_c[W];
		sat_re = 1'b0;
		sat_im = 1'b0;
		if (fc.ovf_re || (fc.neg_re ? (fq_re > W'(32'h8000_0000))
				: (fq_re > W'(32'h7fff_ffff)))) begin
			sat_re = 1'b1;
			f_re   = fc.neg_re ? 32'h8000_0000 : 32'h7fff_ffff;
		end else begin
			f_re = fc.neg_re ? (~fq_re[31:0] + 32'd1) : fq_re[31:0];
		end
		if (fc.ovf_im || (fc.neg_im ? (fq_im > W'(32'h8000_0000))
				: (fq_im > W'(32'h7fff_ffff)))) begin
			sat_im = 1'b1;
			f_im   = fc.neg_im ? 32'h8000_0000 : 32'h7fff_ffff;
		end else begin
			f_im = fc.neg_im ? (~fq_im[31:0] + 32'd1) : fq_im[31:0];
		end
		if (!fc.is_div) begin
			f_re = fc.res_re;
			f_im = fc.res_im;
			f_st = fc.status;
		end else if (fc.status == cau_pkg::ST_DIV0) begin
			f_re = '0;
			f_im = '0;
			f_st = cau_pkg::ST_DIV0;
		end else begin
			f_st = (sat_re || sat_im) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
		end
	end

	logic [31:0] res_re_q, res_im_q;
	logic [1:0]  status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= fc.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_re_q <= f_re;
			res_im_q <= f_im;
			status_q <= f_st;
		end
	end

	assign res_valid = res_valid_q;
	assign res_re    = res_re_q;
	assign res_im    = res_im_q;
	assign status    = status_q;

endmodule

/* rtl/cau_front.sv */
// ----------------------------------------------------------------------------
// cau_front
// products, sums and divider set-up; finishes every operation but division
// ----------------------------------------------------------------------------
module cau_front #(
	parameter int unsigned FRAC_BITS = 16,
	parameter int unsigned W         = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld,
	input  logic [2:0]          kind,
	input  logic signed [31:0]  a_re,
	input  logic signed [31:0]  a_im,
	input  logic signed [31:0]  b_re,
	input  logic signed [31:0]  b_im,
	output cau_pkg::ctl_t       ctl,
	output logic [63:0]         r_re,
	output logic [63:0]         r_im,
	output logic [W-1:0]        dv_re,
	output logic [W-1:0]        dv_im,
	output logic [63:0]         den
);

	// stage 1: products
	logic               vld_s1;
	logic [2:0]         kind_s1;
	logic signed [31:0] ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [63:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, p_bb_s1, p_cc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= kind;
			ar_s1   <= a_re;
			ai_s1   <= a_im;
			br_s1   <= b_re;
			bi_s1   <= b_im;
			p_rr_s1 <= a_re * b_re;
			p_ii_s1 <= a_im * b_im;
			p_ri_s1 <= a_re * b_im;
			p_ir_s1 <= a_im * b_re;
			p_bb_s1 <= b_re * b_re;
			p_cc_s1 <= b_im * b_im;
		end
	end

	// stage 2: sums and the short operations
	logic signed [64:0] nre_c, nim_c, mre_c, mim_c;
	logic signed [64:0] sre_c, sim_c;
	logic [63:0]        den_c;
	cau_pkg::sat_t      xr_c, xi_c;
	cau_pkg::ctl_t      ctl_c;

	always_comb begin
		nre_c = {p_rr_s1[63], p_rr_s1} + {p_ii_s1[63], p_ii_s1};
		nim_c = {p_ir_s1[63], p_ir_s1} - {p_ri_s1[63], p_ri_s1};
		mre_c = {p_rr_s1[63], p_rr_s1} - {p_ii_s1[63], p_ii_s1};
		mim_c = {p_ri_s1[63], p_ri_s1} + {p_ir_s1[63], p_ir_s1};
		den_c = p_bb_s1 + p_cc_s1;
		sre_c = '0;
		sim_c = '0;
		ctl_c = '0;
		ctl_c.valid = vld_s1;
		case (kind_s1)
			cau_pkg::OP_ADD: begin
				sre_c = 65'(ar_s1) + 65'(br_s1);
				sim_c = 65'(ai_s1) + 65'(bi_s1);
			end
			cau_pkg::OP_SUB: begin
				sre_c = 65'(ar_s1) - 65'(br_s1);
				sim_c = 65'(ai_s1) - 65'(bi_s1);
			end
			cau_pkg::OP_MUL: begin
				sre_c = mre_c >>> FRAC_BITS;
				sim_c = mim_c >>> FRAC_BITS;
			end
			cau_pkg::OP_DIV: begin
				ctl_c.is_div = 1'b1;
			end
			cau_pkg::OP_CONJ: begin
				sre_c = 65'(ar_s1);
				sim_c = -65'(ai_s1);
			end
			cau_pkg::OP_NEG: begin
				sre_c = -65'(ar_s1);
				sim_c = -65'(ai_s1);
			end
			default: begin
				sre_c = '0;
				sim_c = '0;
			end
		endcase
		xr_c = cau_pkg::sat65(sre_c);
		xi_c = cau_pkg::sat65(sim_c);
		ctl_c.res_re = xr_c.v;
		ctl_c.res_im = xi_c.v;
		ctl_c.status = (xr_c.f || xi_c.f) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
	end

	cau_pkg::ctl_t      ctl_s2;
	logic signed [64:0] nre_s2, nim_s2;
	logic [63:0]        den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nre_s2 <= nre_c;
			nim_s2 <= nim_c;
			den_s2 <= den_c;
		end
	end

	// stage 3: magnitudes, early overflow and first remainder
	logic [63:0]   mag_re_c, mag_im_c;
	cau_pkg::ctl_t ctl3_c;

	always_comb begin
		mag_re_c = nre_s2[64] ? 64'(-nre_s2) : nre_s2[63:0];
		mag_im_c = nim_s2[64] ? 64'(-nim_s2) : nim_s2[63:0];
		ctl3_c = ctl_s2;
		if (ctl_s2.is_div) begin
			ctl3_c.neg_re = nre_s2[64];
			ctl3_c.neg_im = nim_s2[64];
			ctl3_c.ovf_re = {32'd0, mag_re_c} >= {den_s2, 32'd0};
			ctl3_c.ovf_im = {32'd0, mag_im_c} >= {den_s2, 32'd0};
			ctl3_c.status = (den_s2 == 64'd0) ? cau_pkg::ST_DIV0 : cau_pkg::ST_OK;
		end
	end

	cau_pkg::ctl_t ctl_s3;
	logic [63:0]   r_re_s3, r_im_s3, den_s3;
	logic [W-1:0]  dv_re_s3, dv_im_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s3 <= ctl3_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_re_s3  <= {32'd0, mag_re_c[63:32]};
			r_im_s3  <= {32'd0, mag_im_c[63:32]};
			dv_re_s3 <= W'(mag_re_c[31:0]) << FRAC_BITS;
			dv_im_s3 <= W'(mag_im_c[31:0]) << FRAC_BITS;
			den_s3   <= den_s2;
		end
	end

	assign ctl   = ctl_s3;
	assign r_re  = r_re_s3;
	assign r_im  = r_im_s3;
	assign dv_re = dv_re_s3;
	assign dv_im = dv_im_s3;
	assign den   = den_s3;

endmodule

/* rtl/cau_div_cell.sv */
// ----------------------------------------------------------------------------
// cau_div_cell
// one restoring division step for both parts, one quotient bit per cell
// ----------------------------------------------------------------------------
module cau_div_cell #(
	parameter int unsigned W = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  cau_pkg::ctl_t ctl_i,
	input  logic [63:0]   den_i,
	input  logic [63:0]   r_re_i,
	input  logic [63:0]   r_im_i,
	input  logic [W-1:0]  dv_re_i,
	input  logic [W-1:0]  dv_im_i,
	input  logic [W-1:0]  q_re_i,
	input  logic [W-1:0]  q_im_i,
	output cau_pkg::ctl_t ctl_o,
	output logic [63:0]   den_o,
	output logic [63:0]   r_re_o,
	output logic [63:0]   r_im_o,
	output logic [W-1:0]  dv_re_o,
	output logic [W-1:0]  dv_im_o,
	output logic [W-1:0]  q_re_o,
	output logic [W-1:0]  q_im_o
);

	logic [64:0] t_re, t_im;
	logic        ge_re, ge_im;

	always_comb begin
		t_re  = {r_re_i, dv_re_i[W-1]};
		t_im  = {r_im_i, dv_im_i[W-1]};
		ge_re = t_re >= {1'b0, den_i};
		ge_im = t_im >= {1'b0, den_i};
	end

	cau_pkg::ctl_t ctl_q;
	logic [63:0]   den_q, r_re_q, r_im_q;
	logic [W-1:0]  dv_re_q, dv_im_q, q_re_q, q_im_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_q   <= den_i;
			r_re_q  <= ge_re ? 64'(t_re - {1'b0, den_i}) : t_re[63:0];
			r_im_q  <= ge_im ? 64'(t_im - {1'b0, den_i}) : t_im[63:0];
			dv_re_q <= dv_re_i << 1;
			dv_im_q <= dv_im_i << 1;
			q_re_q  <= {q_re_i[W-2:0], ge_re};
			q_im_q  <= {q_im_i[W-2:0], ge_im};
		end
	end

	assign ctl_o   = ctl_q;
	assign den_o   = den_q;
	assign r_re_o  = r_re_q;
	assign r_im_o  = r_im_q;
	assign dv_re_o = dv_re_q;
	assign dv_im_o = dv_im_q;
	assign q_re_o  = q_re_q;
	assign q_im_o  = q_im_q;

endmodule

/* rtl/cau_checker.sv */
// ----------------------------------------------------------------------------
// cau_port_checks
// port-level checks of the complex arithmetic unit, bound to the top level
// ----------------------------------------------------------------------------
module cau_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_stall,
	input logic [31:0] res_re,
	input logic [31:0] res_im,
	input logic [1:0]  status
);

	// result held while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped under stall");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res_re) && $stable(res_im) && $stable(status))
		else $error("result changed under stall");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> status != 2'd3)
		else $error("undefined status code");

	// divide by zero gives a zero result
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == cau_pkg::ST_DIV0 |-> res_re == 32'd0 && res_im == 32'd0)
		else $error("divide by zero with non-zero result");

	// saturation leaves at least one part at a rail
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == cau_pkg::ST_SAT |->
			res_re == 32'h7fff_ffff || res_re == 32'h8000_0000 ||
			res_im == 32'h7fff_ffff || res_im == 32'h8000_0000)
		else $error("saturation flag without clamped part");

endmodule

bind complex_arith_unit cau_port_checks u_cau_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res_re(res_re),
	.res_im(res_im),
	.status(status)
);

/* dv/cau_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cau_checker
// watches both channels of the complex arithmetic unit, computes the expected
// complex result of every accepted request and compares it in order
// ----------------------------------------------------------------------------
module cau_checker #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               req_valid,
	input  logic               req_stall,
	input  logic [2:0]         kind,
	input  logic signed [31:0] a_re,
	input  logic signed [31:0] a_im,
	input  logic signed [31:0] b_re,
	input  logic signed [31:0] b_im,
	input  logic               res_valid,
	input  logic               res_stall,
	input  logic signed [31:0] res_re,
	input  logic signed [31:0] res_im,
	input  logic [1:0]         status,
	output int                 fail_count,
	output int                 outstanding
);

	typedef struct {
		logic [31:0] re;
		logic [31:0] im;
		logic [1:0]  st;
	} cplx_res_t;

	cplx_res_t exp_results[$];

	function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout bit f);
		if (v > 128'sd2147483647) begin
			f = 1'b1;
			return 32'h7fff_ffff;
		end
		if (v < -128'sd2147483648) begin
			f = 1'b1;
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [127:0] quot(input logic signed [127:0] n,
		input logic signed [127:0] den);
		logic signed [127:0] mag;
		logic signed [127:0] q;
		mag = (n < 0) ? -n : n;
		q = (mag <<< FRAC_BITS) / den;
		return (n < 0) ? -q : q;
	endfunction

	function automatic cplx_res_t complex_result(input logic [2:0] k,
		input logic signed [31:0] ar, input logic signed [31:0] ai,
		input logic signed [31:0] br, input logic signed [31:0] bi);
		cplx_res_t r;
		bit f;
		logic signed [127:0] xr, xi, yr, yi, den;
		f = 1'b0;
		xr = ar;
		xi = ai;
		yr = br;
		yi = bi;
		r.re = '0;
		r.im = '0;
		r.st = cau_pkg::ST_OK;
		case (k)
			cau_pkg::OP_ADD: begin
				r.re = clamp32(xr + yr, f);
				r.im = clamp32(xi + yi, f);
			end
			cau_pkg::OP_SUB: begin
				r.re = clamp32(xr - yr, f);
				r.im = clamp32(xi - yi, f);
			end
			cau_pkg::OP_MUL: begin
				r.re = clamp32((xr * yr - xi * yi) >>> FRAC_BITS, f);
				r.im = clamp32((xr * yi + xi * yr) >>> FRAC_BITS, f);
			end
			cau_pkg::OP_DIV: begin
				den = yr * yr + yi * yi;
				if (den == 0) begin
					r.st = cau_pkg::ST_DIV0;
				end else begin
					r.re = clamp32(quot(xr * yr + xi * yi, den), f);
					r.im = clamp32(quot(xi * yr - xr * yi, den), f);
				end
			end
			cau_pkg::OP_CONJ: begin
				r.re = ar;
				r.im = clamp32(-xi, f);
			end
			cau_pkg::OP_NEG: begin
				r.re = clamp32(-xr, f);
				r.im = clamp32(-xi, f);
			end
			default: ;
		endcase
		if (r.st == cau_pkg::ST_OK && f)
			r.st = cau_pkg::ST_SAT;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t: %s got %h expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
	end

	assign outstanding = exp_results.size();

	// both channels are steady from the falling edge to the next rising edge
	always @(negedge clk) begin
		cplx_res_t e;
		if (req_valid === 1'b1 && req_stall === 1'b0)
			exp_results.push_back(complex_result(kind, a_re, a_im, b_re, b_im));
		if (res_valid === 1'b1 && res_stall === 1'b0) begin
			if (exp_results.size() == 0) begin
				report_mismatch("unexpected result", res_re, 32'h0);
			end else begin
				e = exp_results.pop_front();
				if (res_re !== e.re)
					report_mismatch("res_re", res_re, e.re);
				if (res_im !== e.im)
					report_mismatch("res_im", res_im, e.im);
				if (status !== e.st)
					report_mismatch("status", {30'h0, status}, {30'h0, e.st});
			end
		end
	end

endmodule

/* dv/tb_complex_arith_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_complex_arith_unit
// drives directed and random complex requests through the unit under
// changing idle and stall rates, with one long output hold-off
// ----------------------------------------------------------------------------
module tb_complex_arith_unit;

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	logic [2:0]         kind;
	logic signed [31:0] a_re;
	logic signed [31:0] a_im;
	logic signed [31:0] b_re;
	logic signed [31:0] b_im;
	logic               res_valid;
	logic               res_stall;
	logic signed [31:0] res_re;
	logic signed [31:0] res_im;
	logic [1:0]         status;
	int                 fail_count;
	int                 outstanding;
	int                 send_idle_pct;
	int                 recv_stall_pct;
	int                 hold_cycles;

	complex_arith_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.kind(kind), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
		.res_valid(res_valid), .res_stall(res_stall),
		.res_re(res_re), .res_im(res_im), .status(status)
	);

	cau_checker u_checker (
		.clk(clk),
		.req_valid(req_valid), .req_stall(req_stall),
		.kind(kind), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
		.res_valid(res_valid), .res_stall(res_stall),
		.res_re(res_re), .res_im(res_im), .status(status),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// receiver: random stalls plus a counted hold-off
	initial begin
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				res_stall <= 1'b1;
				hold_cycles = hold_cycles - 1;
			end else begin
				res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	task automatic send_request(input logic [2:0] k, input logic [31:0] ar,
		input logic [31:0] ai, input logic [31:0] br, input logic [31:0] bi);
		bit taken;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		kind <= k;
		a_re <= ar;
		a_im <= ai;
		b_re <= br;
		b_im <= bi;
		do begin
			@(negedge clk);
			taken = !req_stall;
			@(posedge clk);
		end while (!taken);
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3, 4: return $urandom;
			default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
		endcase
	endfunction

	task automatic random_request();
		logic [2:0] k;
		logic [31:0] br, bi;
		k = ($urandom_range(0, 49) == 0) ? 3'($urandom_range(6, 7))
			: 3'($urandom_range(cau_pkg::OP_ADD, cau_pkg::OP_NEG));
		br = pick_operand();
		bi = ($urandom_range(0, 4) == 0) ? 32'h0 : pick_operand();
		if (k == cau_pkg::OP_DIV && $urandom_range(0, 9) == 0) begin
			br = 32'h0;
			bi = 32'h0;
		end
		send_request(k, pick_operand(), pick_operand(), br, bi);
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		kind = cau_pkg::OP_ADD;
		a_re = '0;
		a_im = '0;
		b_re = '0;
		b_im = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(cau_pkg::OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001,
			32'hffff_ffff);
		send_request(cau_pkg::OP_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0);
		send_request(cau_pkg::OP_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001,
			32'hffff_ffff);
		send_request(cau_pkg::OP_SUB, 32'h0005_0000, 32'h0, 32'h0002_8000, 32'h0001_0000);
		send_request(cau_pkg::OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
			32'hffff_0000);
		send_request(cau_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff);
		send_request(cau_pkg::OP_MUL, 32'hffff_ffff, 32'h0, 32'h0000_0001, 32'h0);
		send_request(cau_pkg::OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff);
		send_request(cau_pkg::OP_DIV, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
		send_request(cau_pkg::OP_DIV, 32'h0006_0000, 32'h0002_0000, 32'h0002_0000, 32'h0);
		send_request(cau_pkg::OP_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
			32'hffff_0000);
		send_request(cau_pkg::OP_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0);
		send_request(cau_pkg::OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff);
		send_request(cau_pkg::OP_DIV, 32'hffff_ffff, 32'h0000_0001, 32'h0003_0000,
			32'h0007_0000);
		send_request(cau_pkg::OP_CONJ, 32'h8000_0000, 32'h8000_0000, 32'h1234_5678, 32'h1);
		send_request(cau_pkg::OP_CONJ, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0);
		send_request(cau_pkg::OP_NEG, 32'h8000_0000, 32'h0001_0000, 32'h0, 32'h0);
		send_request(cau_pkg::OP_NEG, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
			32'hffff_ffff);
		send_request(3'd6, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		send_request(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

		// long hold-off so the pipeline fills and stalls requests
		hold_cycles = 300;
		repeat (230) random_request();
		send_idle_pct = 51;
		repeat (230) random_request();
		send_idle_pct = 0;
		recv_stall_pct = 51;
		repeat (230) random_request();
		send_idle_pct = 36;
		recv_stall_pct = 36;
		repeat (230) random_request();
		req_valid <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* complex_arith_unit.f */
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_div_cell.sv
rtl/complex_arith_unit.sv
rtl/cau_checker.sv
dv/cau_checker.sv
dv/tb_complex_arith_unit.sv
